// ===== sv/lgpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgpb_pkg
// Shared types, widths and register codes for the linear gradient pixel blend.
// ----------------------------------------------------------------------------
package lgpb_pkg;

    // Coordinate and pixel widths
    localparam int COORD_BITS = 12;
    localparam int CHAN_W     = 8;

    // Configuration register widths
    localparam int DIR_W      = 16;
    localparam int MINP_W     = 29;
    localparam int ISPAN_W    = 25;
    localparam int STR_W      = 17;
    localparam int TGT_W      = 3 * CHAN_W;
    localparam int CFG_DATA_W = MINP_W;
    localparam int REG_IDX_W  = 3;

    // Projection datapath widths
    localparam int PROD_W  = COORD_BITS + 1 + DIR_W;
    localparam int PROJ_W  = PROD_W + 1;
    localparam int DIFF_W  = ((PROJ_W > MINP_W) ? PROJ_W : MINP_W) + 1;
    localparam int DPOS_W  = DIFF_W - 1;
    localparam int TPROD_W = DPOS_W + ISPAN_W;
    localparam int T_SHIFT = 22;
    localparam int TFULL_W = TPROD_W - T_SHIFT;

    // Q1.16 amount
    localparam int FRAC_W = 16;
    localparam int AMT_W  = FRAC_W + 1;
    localparam int TS_W   = 2 * AMT_W;
    localparam logic [AMT_W-1:0] AMT_ONE = AMT_W'(1 << FRAC_W);
    localparam logic [FRAC_W-1:0] ROUND_HALF = FRAC_W'(1 << (FRAC_W - 1));

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_DIR_X      = 3'd0,
        REG_DIR_Y      = 3'd1,
        REG_MIN_PROJ   = 3'd2,
        REG_INV_SPAN   = 3'd3,
        REG_STRENGTH   = 3'd4,
        REG_TO_COLOR   = 3'd5,
        REG_TARGET_RGB = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [DIR_W-1:0]  dir_x;
        logic signed [DIR_W-1:0]  dir_y;
        logic signed [MINP_W-1:0] min_projection;
        logic [ISPAN_W-1:0]       inverse_span;
        logic [STR_W-1:0]         strength;
        logic                     to_color;
        logic [TGT_W-1:0]         target_rgb;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [AMT_W-1:0] amount;
        pixel_t           pixel;
    } queue_entry_t;

endpackage

// ===== sv/lgpb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgpb_front
// Four-stage pipeline: projects the coordinate, clamps to the span and
// computes the Q1.16 blend amount for each pixel.
// ----------------------------------------------------------------------------
module lgpb_front
    import lgpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  pixel_t                in_pixel,
    output logic                  out_valid,
    input  logic                  out_ready,
    output queue_entry_t          out_entry
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic en1, en2, en3, en4;

    logic signed [PROD_W-1:0] px_reg, py_reg, px_next, py_next;
    logic [DPOS_W-1:0]        dpos_reg, dpos_next;
    logic [TFULL_W-1:0]       tfull_reg, tfull_next;
    logic [TS_W-1:0]          ts_reg, ts_next;
    pixel_t                   pix1_reg, pix2_reg, pix3_reg, pix4_reg;

    logic signed [DIFF_W-1:0] diff;
    logic [TPROD_W-1:0]       tprod;
    logic [AMT_W-1:0]         t_sat;
    logic [AMT_W-1:0]         s_sat;
    logic [TS_W:0]            ts_round;

    // Stage enables: a stage moves when it is empty or its successor moves
    assign en4      = !s4_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    // Stage 1: coordinate products
    always_comb
    begin
        px_next = PROD_W'($signed({1'b0, pos_x})) * PROD_W'(cfg.dir_x);
        py_next = PROD_W'($signed({1'b0, pos_y})) * PROD_W'(cfg.dir_y);
    end

    // Stage 2: distance past the minimum projection, zero when not positive
    always_comb
    begin
        diff = DIFF_W'(px_reg) + DIFF_W'(py_reg) - DIFF_W'(cfg.min_projection);
        if (!diff[DIFF_W-1] && (diff != '0))
        begin
            dpos_next = diff[DPOS_W-1:0];
        end
        else
        begin
            dpos_next = '0;
        end
    end

    // Stage 3: scale by the reciprocal span
    always_comb
    begin
        tprod      = TPROD_W'(dpos_reg) * TPROD_W'(cfg.inverse_span);
        tfull_next = tprod[TPROD_W-1:T_SHIFT];
    end

    // Stage 4: saturate t and strength, multiply
    always_comb
    begin
        t_sat   = (tfull_reg > TFULL_W'(AMT_ONE)) ? AMT_ONE : tfull_reg[AMT_W-1:0];
        s_sat   = (cfg.strength > STR_W'(AMT_ONE)) ? AMT_ONE : cfg.strength[AMT_W-1:0];
        ts_next = TS_W'(t_sat) * TS_W'(s_sat);
    end

    // Rounded amount toward the queue
    assign ts_round         = {1'b0, ts_reg} + (TS_W + 1)'(ROUND_HALF);
    assign out_entry.amount = ts_round[FRAC_W +: AMT_W];
    assign out_entry.pixel  = pix4_reg;
    assign out_valid        = s4_valid_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= in_valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            pix1_reg <= in_pixel;
        end
        if (en2)
        begin
            dpos_reg <= dpos_next;
            pix2_reg <= pix1_reg;
        end
        if (en3)
        begin
            tfull_reg <= tfull_next;
            pix3_reg  <= pix2_reg;
        end
        if (en4)
        begin
            ts_reg   <= ts_next;
            pix4_reg <= pix3_reg;
        end
    end

endmodule

// ===== sv/lgpb_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgpb_fifo
// Short queue that decouples the amount pipeline from the blend stage.
// ----------------------------------------------------------------------------
module lgpb_fifo
    import lgpb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  queue_entry_t wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output queue_entry_t rd_data
);

    queue_entry_t            mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    push, pop;

    assign wr_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    // Occupancy never exceeds the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("lgpb_fifo: occupancy above depth");

    // A lone push grows the occupancy by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("lgpb_fifo: push not counted");

    // A lone pop shrinks the occupancy by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("lgpb_fifo: pop not counted");

    // Pointers are equal exactly when the queue is empty or full
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg == rd_ptr_reg) == ((count_reg == '0) ||
                                       (count_reg == FIFO_CNT_W'(FIFO_DEPTH))))
        else $error("lgpb_fifo: pointers and occupancy disagree");
`endif

endmodule

// ===== sv/lgpb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgpb_back
// Blends the color channels toward the target color, or fades alpha toward
// zero, by the amount, rounds half up and holds the result in the output register.
// ----------------------------------------------------------------------------
module lgpb_back
    import lgpb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  queue_entry_t      q_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pixel_t            out_pixel
);

    localparam int MIX_W = CHAN_W + AMT_W;

    logic             b1_valid_reg;
    logic             out_valid_reg;
    logic             en_b1, en_out;
    logic [MIX_W-1:0] mix_reg  [4];
    logic [MIX_W-1:0] mix_next [4];
    pixel_t           out_pixel_reg, out_pixel_next;
    logic [AMT_W-1:0] amt_rgb, amt_alpha;

    // c * (1 - a) + target * a, in Q16
    function automatic logic [MIX_W-1:0] mix_chan(input logic [CHAN_W-1:0] c,
                                                  input logic [CHAN_W-1:0] tgt,
                                                  input logic [AMT_W-1:0]  a);
        logic [AMT_W-1:0] inv;
        inv = AMT_ONE - a;
        return (MIX_W'(c) * MIX_W'(inv)) + (MIX_W'(tgt) * MIX_W'(a));
    endfunction

    // Round half up and clamp to the channel range
    function automatic logic [CHAN_W-1:0] round_chan(input logic [MIX_W-1:0] m);
        logic [MIX_W:0] r;
        r = {1'b0, m} + (MIX_W + 1)'(ROUND_HALF);
        return (r[MIX_W:FRAC_W] > (MIX_W + 1 - FRAC_W)'({CHAN_W{1'b1}}))
               ? {CHAN_W{1'b1}} : r[FRAC_W +: CHAN_W];
    endfunction

    assign en_out  = !out_valid_reg || out_ready;
    assign en_b1   = !b1_valid_reg || en_out;
    assign q_ready = en_b1;

    // A zero amount passes a channel through unchanged
    assign amt_rgb   = cfg.to_color ? q_data.amount : '0;
    assign amt_alpha = cfg.to_color ? '0 : q_data.amount;

    // Blend products
    always_comb
    begin
        mix_next[0] = mix_chan(q_data.pixel.red,   cfg.target_rgb[2*CHAN_W +: CHAN_W],
                               amt_rgb);
        mix_next[1] = mix_chan(q_data.pixel.green, cfg.target_rgb[CHAN_W +: CHAN_W],
                               amt_rgb);
        mix_next[2] = mix_chan(q_data.pixel.blue,  cfg.target_rgb[0 +: CHAN_W], amt_rgb);
        mix_next[3] = mix_chan(q_data.pixel.alpha, '0, amt_alpha);
    end

    // Rounding into the output register
    always_comb
    begin
        out_pixel_next.red   = round_chan(mix_reg[0]);
        out_pixel_next.green = round_chan(mix_reg[1]);
        out_pixel_next.blue  = round_chan(mix_reg[2]);
        out_pixel_next.alpha = round_chan(mix_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_b1)  b1_valid_reg  <= q_valid;
            if (en_out) out_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b1)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mix_reg[i] <= mix_next[i];
            end
        end
        if (en_out)
        begin
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

endmodule

// ===== sv/linear_gradient_pixel_blend.sv =====
`timescale 1ns / 1ps
// Each pixel passes the four amount stages, the queue, the blend register and the output register.
// Throughput: one pixel per clock unless the output stalls; every stage is a single register step.
// A 4-entry queue between the amount pipeline and the blend stage absorbs
// output stalls, so input is taken while a finished result waits.
// Reset (rst_n low, asynchronous) empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
// linear_gradient_pixel_blend
// Linear gradient color blend or alpha fade over a stream of RGBA pixels.
// ----------------------------------------------------------------------------
module linear_gradient_pixel_blend
    import lgpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic [CHAN_W-1:0]     in_red,
    input  logic [CHAN_W-1:0]     in_green,
    input  logic [CHAN_W-1:0]     in_blue,
    input  logic [CHAN_W-1:0]     in_alpha,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHAN_W-1:0]     out_red,
    output logic [CHAN_W-1:0]     out_green,
    output logic [CHAN_W-1:0]     out_blue,
    output logic [CHAN_W-1:0]     out_alpha
);

    cfg_t         cfg_reg, cfg_next;
    pixel_t       in_pixel, out_pixel;
    logic         f_valid, f_ready, q_valid, q_ready;
    queue_entry_t f_entry, q_entry;

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_DIR_X:      cfg_next.dir_x          = cfg_data[DIR_W-1:0];
                REG_DIR_Y:      cfg_next.dir_y          = cfg_data[DIR_W-1:0];
                REG_MIN_PROJ:   cfg_next.min_projection = cfg_data[MINP_W-1:0];
                REG_INV_SPAN:   cfg_next.inverse_span   = cfg_data[ISPAN_W-1:0];
                REG_STRENGTH:   cfg_next.strength       = cfg_data[STR_W-1:0];
                REG_TO_COLOR:   cfg_next.to_color       = cfg_data[0];
                REG_TARGET_RGB: cfg_next.target_rgb     = cfg_data[TGT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dir_x          <= DIR_W'(16384);
            cfg_reg.dir_y          <= '0;
            cfg_reg.min_projection <= '0;
            cfg_reg.inverse_span   <= ISPAN_W'(4096);
            cfg_reg.strength       <= STR_W'(AMT_ONE);
            cfg_reg.to_color       <= 1'b0;
            cfg_reg.target_rgb     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input pixel bundle
    assign in_pixel.red   = in_red;
    assign in_pixel.green = in_green;
    assign in_pixel.blue  = in_blue;
    assign in_pixel.alpha = in_alpha;

    lgpb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .in_pixel  (in_pixel),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_entry (f_entry)
    );

    lgpb_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_entry)
    );

    lgpb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_entry),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (out_pixel)
    );

    assign out_red   = out_pixel.red;
    assign out_green = out_pixel.green;
    assign out_blue  = out_pixel.blue;
    assign out_alpha = out_pixel.alpha;

endmodule

// ===== dv/linear_gradient_pixel_blend_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_gradient_pixel_blend_test
// Self-checking bench for the gradient blend. A queue-fed driver sends pixels
// under random stalls. Each accepted transaction is run through a local
// fixed-point model of the projection, clamp and blend, and the expected
// pixel is queued. The monitor checks every output transaction in order.
// Registers are reprogrammed between phases, only while the pipe is empty.
// ----------------------------------------------------------------------------
module linear_gradient_pixel_blend_test;
    import lgpb_pkg::*;

    localparam int  PIPE_LATENCY = 6;
    localparam int  CYCLE_LIMIT  = 300000;
    localparam int  RAND_PHASES  = 8;
    localparam int  PHASE_PIXELS = 86;
    localparam int  CALM_PHASE   = 3;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Gradient register limits
    localparam longint DIR_ONE   = 16384;
    localparam longint MINP_MAX  = 134217728;
    localparam longint ISPAN_MAX = 16777216;
    localparam longint STR_ONE   = 65536;
    localparam longint STR_TOP   = 131071;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        pixel_t                pix;
    } pixel_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [COORD_BITS-1:0] pos_x = '0;
    logic [COORD_BITS-1:0] pos_y = '0;
    logic [CHAN_W-1:0]     in_red = '0;
    logic [CHAN_W-1:0]     in_green = '0;
    logic [CHAN_W-1:0]     in_blue = '0;
    logic [CHAN_W-1:0]     in_alpha = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CHAN_W-1:0]     out_red;
    logic [CHAN_W-1:0]     out_green;
    logic [CHAN_W-1:0]     out_blue;
    logic [CHAN_W-1:0]     out_alpha;

    pixel_item_t pending_pixels[$];
    pixel_t      expected_pixels[$];
    pixel_item_t held_pixel;
    cfg_t        cfg_shadow;
    logic        in_taken = 1'b0;
    bit          calm = 1'b0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          img_w = 4096;
    int          img_h = 4096;

    linear_gradient_pixel_blend DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

    always #1 clk = ~clk;

    // One channel moved toward its target, rounded half up
    function automatic logic [CHAN_W-1:0] mix_channel(logic [CHAN_W-1:0] base,
                                                      logic [CHAN_W-1:0] goal,
                                                      longint amount);
        longint mixed;
        mixed = (longint'(base) * (STR_ONE - amount) + longint'(goal) * amount + 32768) >> 16;
        if (mixed > 255)
            mixed = 255;
        return CHAN_W'(mixed);
    endfunction

    // Project, clamp, scale by strength, then blend color or fade alpha
    function automatic pixel_t blend_pixel(cfg_t c, pixel_item_t it);
        longint proj;
        longint diff;
        longint t;
        longint s;
        longint amount;
        pixel_t res;
        proj = longint'(it.x) * longint'($signed(c.dir_x))
             + longint'(it.y) * longint'($signed(c.dir_y));
        diff = proj - longint'($signed(c.min_projection));
        if (diff <= 0)
            t = 0;
        else
        begin
            t = (diff * longint'(c.inverse_span)) >> T_SHIFT;
            if (t > STR_ONE)
                t = STR_ONE;
        end
        s = (longint'(c.strength) > STR_ONE) ? STR_ONE : longint'(c.strength);
        amount = (t * s + 32768) >> 16;
        res = it.pix;
        if (c.to_color)
        begin
            res.red   = mix_channel(it.pix.red,   c.target_rgb[23:16], amount);
            res.green = mix_channel(it.pix.green, c.target_rgb[15:8],  amount);
            res.blue  = mix_channel(it.pix.blue,  c.target_rgb[7:0],   amount);
        end
        else
            res.alpha = mix_channel(it.pix.alpha, '0, amount);
        return res;
    endfunction

    // Register write; the shadow copy keeps only the register's own bits
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, longint value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_DIR_X:      cfg_shadow.dir_x          = DIR_W'(value);
            REG_DIR_Y:      cfg_shadow.dir_y          = DIR_W'(value);
            REG_MIN_PROJ:   cfg_shadow.min_projection = MINP_W'(value);
            REG_INV_SPAN:   cfg_shadow.inverse_span   = ISPAN_W'(value);
            REG_STRENGTH:   cfg_shadow.strength       = STR_W'(value);
            REG_TO_COLOR:   cfg_shadow.to_color       = 1'(value);
            REG_TARGET_RGB: cfg_shadow.target_rgb     = TGT_W'(value);
            default: ;
        endcase
    endtask

    task automatic write_all(longint dx, longint dy, longint minp, longint ispan,
                             longint strength, longint to_color, longint target);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_MIN_PROJ, minp);
        write_reg(REG_INV_SPAN, ispan);
        write_reg(REG_STRENGTH, strength);
        write_reg(REG_TO_COLOR, to_color);
        write_reg(REG_TARGET_RGB, target);
    endtask

    task automatic push_pixel(int x, int y, int r, int g, int b, int a);
        pixel_item_t it;
        it.x = COORD_BITS'(x);
        it.y = COORD_BITS'(y);
        it.pix = '{red: CHAN_W'(r), green: CHAN_W'(g), blue: CHAN_W'(b), alpha: CHAN_W'(a)};
        pending_pixels.insert(pending_pixels.size(), it);
    endtask

    function automatic int rand_channel();
        case ($urandom_range(9))
            0: return 0;
            1: return 255;
            default: return int'($urandom_range(255));
        endcase
    endfunction

    // Mostly inside the programmed image, sometimes anywhere
    task automatic push_random_pixels(int count);
        int x;
        int y;
        repeat (count)
        begin
            if ($urandom_range(9) < 8)
            begin
                x = int'($urandom_range(img_w - 1));
                y = int'($urandom_range(img_h - 1));
            end
            else
            begin
                x = int'($urandom_range(4095));
                y = int'($urandom_range(4095));
            end
            push_pixel(x, y, rand_channel(), rand_channel(), rand_channel(), rand_channel());
        end
    endtask

    // Random gradient: realistic image geometry, raw register values or extremes
    task automatic random_gradient();
        longint dx;
        longint dy;
        longint lo;
        longint hi;
        longint span;
        longint minp;
        longint ispan;
        longint strength;
        dx = longint'($urandom_range(32768)) - DIR_ONE;
        dy = longint'($urandom_range(32768)) - DIR_ONE;
        strength = ($urandom_range(4) == 0) ? longint'($urandom_range(STR_TOP))
                                            : longint'($urandom_range(STR_ONE));
        case ($urandom_range(3))
            0, 1:
            begin
                img_w = ($urandom_range(1) == 0) ? int'($urandom_range(64, 1))
                                                 : int'($urandom_range(4096, 1));
                img_h = ($urandom_range(1) == 0) ? int'($urandom_range(64, 1))
                                                 : int'($urandom_range(4096, 1));
                lo = ((img_w - 1) * dx < 0 ? (img_w - 1) * dx : 0)
                   + ((img_h - 1) * dy < 0 ? (img_h - 1) * dy : 0);
                hi = ((img_w - 1) * dx > 0 ? (img_w - 1) * dx : 0)
                   + ((img_h - 1) * dy > 0 ? (img_h - 1) * dy : 0);
                span = hi - lo;
                ispan = (span == 0) ? ISPAN_MAX : (longint'(1) << 38) / span;
                if (ispan > ISPAN_MAX)
                    ispan = ISPAN_MAX;
                minp = lo;
            end
            2:
            begin
                img_w = 4096;
                img_h = 4096;
                minp  = longint'($urandom_range(2 * MINP_MAX)) - MINP_MAX;
                ispan = longint'($urandom_range(ISPAN_MAX));
            end
            default:
            begin
                img_w = 4096;
                img_h = 4096;
                dx = ($urandom_range(1) == 0) ? -DIR_ONE : DIR_ONE;
                dy = ($urandom_range(2) == 0) ? 0
                   : (($urandom_range(1) == 0) ? -DIR_ONE : DIR_ONE);
                minp  = ($urandom_range(1) == 0) ? -MINP_MAX : 0;
                ispan = ($urandom_range(2) == 0) ? 0 : ISPAN_MAX >> $urandom_range(14);
                strength = ($urandom_range(1) == 0) ? STR_TOP : 0;
            end
        endcase
        write_all(dx, dy, minp, ispan, strength, longint'($urandom_range(1)),
                  longint'($urandom_range(24'hFFFFFF)));
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, longint'($urandom));
    endtask

    // Let the queue, the driver and the pipe run empty
    task automatic drain();
        do
            @(posedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    // Input driver: hold each transaction until taken, idle at random
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= 25))
            begin
                held_pixel = pending_pixels.pop_front();
                in_valid <= 1'b1;
                pos_x    <= held_pixel.x;
                pos_y    <= held_pixel.y;
                in_red   <= held_pixel.pix.red;
                in_green <= held_pixel.pix.green;
                in_blue  <= held_pixel.pix.blue;
                in_alpha <= held_pixel.pix.alpha;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= 25);
    end

    // Monitor: check outputs in order, predict each accepted input
    always @(posedge clk)
    begin
        pixel_t want;
        cycle_count++;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("output transaction with nothing expected");
                    error_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_red !== want.red)
                    begin
                        $error("out_red expected %0d got %0d", want.red, out_red);
                        error_count++;
                    end
                    if (out_green !== want.green)
                    begin
                        $error("out_green expected %0d got %0d", want.green, out_green);
                        error_count++;
                    end
                    if (out_blue !== want.blue)
                    begin
                        $error("out_blue expected %0d got %0d", want.blue, out_blue);
                        error_count++;
                    end
                    if (out_alpha !== want.alpha)
                    begin
                        $error("out_alpha expected %0d got %0d", want.alpha, out_alpha);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_pixels.insert(expected_pixels.size(),
                                       blend_pixel(cfg_shadow, held_pixel));
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        cfg_shadow.dir_x          = DIR_W'(DIR_ONE);
        cfg_shadow.dir_y          = '0;
        cfg_shadow.min_projection = '0;
        cfg_shadow.inverse_span   = ISPAN_W'(4096);
        cfg_shadow.strength       = STR_W'(STR_ONE);
        cfg_shadow.to_color       = 1'b0;
        cfg_shadow.target_rgb     = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: alpha fade along x
        push_pixel(0, 0, 255, 255, 255, 255);
        push_pixel(4095, 4095, 0, 0, 0, 255);
        push_pixel(4095, 0, 255, 0, 255, 0);
        push_pixel(2048, 1234, 128, 127, 1, 200);
        drain();

        // Extreme registers, strength above one saturates, projection past span
        write_all(-DIR_ONE, DIR_ONE, -MINP_MAX, ISPAN_MAX, STR_TOP, 1, 24'hFFFFFF);
        write_reg(REG_UNUSED, (longint'(1) << CFG_DATA_W) - 1);
        push_pixel(0, 0, 0, 0, 0, 0);
        push_pixel(4095, 0, 0, 128, 255, 255);
        push_pixel(0, 4095, 255, 255, 255, 0);
        push_pixel(4095, 4095, 17, 34, 51, 68);
        drain();

        // Zero inverse span leaves pixels untouched
        write_all(DIR_ONE, DIR_ONE, 0, 0, STR_ONE, 1, 24'h00FF00);
        push_pixel(4095, 4095, 255, 0, 255, 255);
        push_pixel(1, 1, 0, 255, 0, 0);
        drain();

        // Projection below the minimum gives no amount
        write_all(DIR_ONE, DIR_ONE, MINP_MAX, ISPAN_MAX, STR_ONE, 0, 24'h123456);
        push_pixel(4095, 4095, 255, 255, 255, 255);
        push_pixel(0, 0, 0, 0, 0, 255);
        drain();

        // Partial amounts for rounding, then zero strength
        write_all(DIR_ONE, 0, 0, 16384, 32768, 1, 24'h80FF01);
        push_pixel(512, 7, 0, 0, 255, 9);
        push_pixel(513, 0, 255, 1, 0, 9);
        push_pixel(1023, 4095, 127, 128, 129, 9);
        drain();
        write_reg(REG_STRENGTH, 0);
        push_pixel(2000, 100, 10, 20, 30, 40);
        push_pixel(4095, 4095, 255, 255, 255, 255);
        drain();

        // Random phases, one of them without any stalls
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            random_gradient();
            calm = (phase == CALM_PHASE);
            push_random_pixels(PHASE_PIXELS);
            drain();
        end
        calm = 1'b0;

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
